// ----- rtl/bts_pkg.sv -----
// Shared types, constants and widths of the bilinear texture sampler.
package bts_pkg;

  // Default texture store geometry
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  // Field widths
  localparam int SIZE_W  = 9;               // size registers and texel coordinates
  localparam int COORD_W = 17;              // unsigned 0.16 with room for 1.0
  localparam int FRAC_W  = 16;
  localparam int ADDR_W  = 16;              // texel_addr field
  localparam int RGB_W   = 24;
  localparam int CH_W    = 8;
  localparam int POS_W   = COORD_W + SIZE_W; // scaled position, 10.16
  localparam int ROW_W   = 2 * SIZE_W;      // y times width
  localparam int SUM_W   = ROW_W + 1;       // x plus row base
  localparam int WT_W    = 2 * COORD_W - 1; // corner weight, at most 2^32
  localparam int PROD_W  = CH_W + WT_W;
  localparam int ACC_W   = 40;              // channel sum scaled by 2^32
  localparam int CFG_IDX_W = 8;
  localparam int IN_DATA_W = 80;

  // Output queue
  localparam int OUT_DEPTH = 2;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam logic [COORD_W-1:0] ONE_016    = 17'h10000;
  localparam logic [ACC_W-1:0]   ROUND_HALF = 40'h0080000000;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 8'd1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  // One texel read issued by the sequencer, seen by the blend side
  typedef struct packed {
    logic            valid;
    logic            in_range;
    logic            first;
    logic            last;
    logic [WT_W-1:0] wt;
  } rd_info_t;

endpackage

// ----- rtl/bts_ram.sv -----
// Generic single-port RAM with registered read data.
module bts_ram #(
  parameter int DATA_W = 24,
  parameter int DEPTH  = 65536,
  parameter int AW     = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write on request, read the addressed entry every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/bts_front.sv -----
// Input stage, position scaling and texel read sequencer driving the store port.
module bts_front #(
  parameter int MAX_WIDTH  = bts_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bts_pkg::DEF_MAX_HEIGHT,
  parameter int AW         = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // accepted item
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bts_pkg::op_e                  in_op_i,
  input  logic [bts_pkg::ADDR_W-1:0]    in_addr_i,
  input  logic [bts_pkg::RGB_W-1:0]     in_rgb_i,
  input  logic [bts_pkg::COORD_W-1:0]   in_u_i,
  input  logic [bts_pkg::COORD_W-1:0]   in_v_i,
  // size registers
  input  logic [bts_pkg::SIZE_W-1:0]    tex_width_i,
  input  logic [bts_pkg::SIZE_W-1:0]    tex_height_i,
  // result taken at the output
  input  logic                          pop_i,
  // store port
  output logic                          ram_we_o,
  output logic [AW-1:0]                 ram_addr_o,
  output logic [bts_pkg::RGB_W-1:0]     ram_wdata_o,
  // read info, aligned with the store read data
  output bts_pkg::rd_info_t             rd_o
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

  // ---------------- stage 1: clamp and scale ----------------
  logic [bts_pkg::SIZE_W-1:0]  w_c, h_c, wm1_c, hm1_c;
  logic [bts_pkg::COORD_W-1:0] u_c, vc_c, vf_c;
  logic [bts_pkg::POS_W-1:0]   px_c, py_c;

  logic                        f1_v_q;
  bts_pkg::op_e                f1_op_q;
  logic [bts_pkg::ADDR_W-1:0]  f1_addr_q;
  logic [bts_pkg::RGB_W-1:0]   f1_rgb_q;
  logic [bts_pkg::POS_W-1:0]   f1_px_q, f1_py_q;
  logic [bts_pkg::SIZE_W-1:0]  f1_w_q, f1_wm1_q, f1_hm1_q;

  logic                        f1_move;
  logic                        in_acc;

  // Clamp sizes to the store geometry, a zero size acts as one
  always_comb begin
    if (tex_width_i == '0) begin
      w_c = bts_pkg::SIZE_W'(1);
    end else if (32'(tex_width_i) > MAX_WIDTH) begin
      w_c = bts_pkg::SIZE_W'(MAX_WIDTH);
    end else begin
      w_c = tex_width_i;
    end
    if (tex_height_i == '0) begin
      h_c = bts_pkg::SIZE_W'(1);
    end else if (32'(tex_height_i) > MAX_HEIGHT) begin
      h_c = bts_pkg::SIZE_W'(MAX_HEIGHT);
    end else begin
      h_c = tex_height_i;
    end
  end

  assign wm1_c = w_c - bts_pkg::SIZE_W'(1);
  assign hm1_c = h_c - bts_pkg::SIZE_W'(1);

  // Saturate coordinates at 1.0 and flip v
  assign u_c  = (in_u_i > bts_pkg::ONE_016) ? bts_pkg::ONE_016 : in_u_i;
  assign vc_c = (in_v_i > bts_pkg::ONE_016) ? bts_pkg::ONE_016 : in_v_i;
  assign vf_c = bts_pkg::ONE_016 - vc_c;

  assign px_c = bts_pkg::POS_W'(u_c) * bts_pkg::POS_W'(wm1_c);
  assign py_c = bts_pkg::POS_W'(vf_c) * bts_pkg::POS_W'(hm1_c);

  assign in_acc     = in_valid_i & in_ready_o;
  assign in_ready_o = ~f1_v_q | f1_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
    end else if (in_acc) begin
      f1_v_q <= 1'b1;
    end else if (f1_move) begin
      f1_v_q <= 1'b0;
    end
  end

  // Capture payload on every accepted beat
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      f1_op_q   <= in_op_i;
      f1_addr_q <= in_addr_i;
      f1_rgb_q  <= in_rgb_i;
      f1_px_q   <= px_c;
      f1_py_q   <= py_c;
      f1_w_q    <= w_c;
      f1_wm1_q  <= wm1_c;
      f1_hm1_q  <= hm1_c;
    end
  end

  // ---------------- corner split, row bases and weights ----------------
  logic [bts_pkg::SIZE_W-1:0]  x0_c, y0_c, x1_c, y1_c;
  logic [bts_pkg::SIZE_W:0]    x1w_c, y1w_c;
  logic [bts_pkg::FRAC_W-1:0]  fx_c, fy_c;
  logic [bts_pkg::ROW_W-1:0]   row0_c, row1_c;

  assign x0_c = f1_px_q[bts_pkg::FRAC_W +: bts_pkg::SIZE_W];
  assign y0_c = f1_py_q[bts_pkg::FRAC_W +: bts_pkg::SIZE_W];
  assign fx_c = f1_px_q[bts_pkg::FRAC_W-1:0];
  assign fy_c = f1_py_q[bts_pkg::FRAC_W-1:0];

  assign x1w_c = {1'b0, x0_c} + {{bts_pkg::SIZE_W{1'b0}}, (fx_c != '0)};
  assign y1w_c = {1'b0, y0_c} + {{bts_pkg::SIZE_W{1'b0}}, (fy_c != '0)};
  assign x1_c  = (x1w_c > {1'b0, f1_wm1_q}) ? f1_wm1_q : x1w_c[bts_pkg::SIZE_W-1:0];
  assign y1_c  = (y1w_c > {1'b0, f1_hm1_q}) ? f1_hm1_q : y1w_c[bts_pkg::SIZE_W-1:0];

  assign row0_c = bts_pkg::ROW_W'(y0_c) * bts_pkg::ROW_W'(f1_w_q);
  assign row1_c = bts_pkg::ROW_W'(y1_c) * bts_pkg::ROW_W'(f1_w_q);

  // ---------------- sequencer: at most one store access per cycle ----------------
  logic                          is_v_q;
  bts_pkg::op_e                  is_op_q;
  logic [1:0]                    is_cnt_q;
  logic [bts_pkg::ADDR_W-1:0]    is_addr_q;
  logic [bts_pkg::RGB_W-1:0]     is_rgb_q;
  logic [bts_pkg::SIZE_W-1:0]    is_x0_q, is_x1_q;
  logic [bts_pkg::ROW_W-1:0]     is_row0_q, is_row1_q;
  logic [bts_pkg::COORD_W-1:0]   is_wx0_q, is_wx1_q, is_wy0_q, is_wy1_q;
  logic [bts_pkg::OUT_CNT_W-1:0] outst_q, outst_d;

  logic                          is_done, is_free, credit_ok;
  logic                          smp_load;

  assign is_done   = is_v_q & ((is_op_q == bts_pkg::OP_WRITE) | (is_cnt_q == 2'd3));
  assign is_free   = ~is_v_q | is_done;
  assign credit_ok = outst_q < bts_pkg::OUT_CNT_W'(bts_pkg::OUT_DEPTH);
  assign f1_move   = f1_v_q & is_free & ((f1_op_q == bts_pkg::OP_WRITE) | credit_ok);
  assign smp_load  = f1_move & (f1_op_q == bts_pkg::OP_SAMPLE);

  // Count samples from start of reads until their result leaves
  always_comb begin
    outst_d = outst_q;
    if (smp_load && !pop_i) begin
      outst_d = outst_q + bts_pkg::OUT_CNT_W'(1);
    end else if (!smp_load && pop_i) begin
      outst_d = outst_q - bts_pkg::OUT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_v_q   <= 1'b0;
      is_cnt_q <= 2'd0;
      outst_q  <= '0;
    end else begin
      outst_q <= outst_d;
      if (f1_move) begin
        is_v_q   <= 1'b1;
        is_cnt_q <= 2'd0;
      end else begin
        if (is_done) begin
          is_v_q <= 1'b0;
        end
        if (is_v_q) begin
          is_cnt_q <= is_cnt_q + 2'd1;
        end
      end
    end
  end

  // Load the next item into the sequencer
  always_ff @(posedge clk_i) begin
    if (f1_move) begin
      is_op_q   <= f1_op_q;
      is_addr_q <= f1_addr_q;
      is_rgb_q  <= f1_rgb_q;
      is_x0_q   <= x0_c;
      is_x1_q   <= x1_c;
      is_row0_q <= row0_c;
      is_row1_q <= row1_c;
      is_wx0_q  <= bts_pkg::ONE_016 - {1'b0, fx_c};
      is_wx1_q  <= {1'b0, fx_c};
      is_wy0_q  <= bts_pkg::ONE_016 - {1'b0, fy_c};
      is_wy1_q  <= {1'b0, fy_c};
    end
  end

  // Corner order: (x0,y0) (x1,y0) (x0,y1) (x1,y1)
  logic [bts_pkg::SIZE_W-1:0]    xsel_c;
  logic [bts_pkg::ROW_W-1:0]     rowsel_c;
  logic [bts_pkg::SUM_W-1:0]     sum_c;
  logic [bts_pkg::COORD_W-1:0]   wxs_c, wys_c;
  logic [2*bts_pkg::COORD_W-1:0] wprod_c;
  logic                          rd_in_c, wr_in_c;
  bts_pkg::rd_info_t             rd_q;

  assign xsel_c   = is_cnt_q[0] ? is_x1_q : is_x0_q;
  assign rowsel_c = is_cnt_q[1] ? is_row1_q : is_row0_q;
  assign sum_c    = bts_pkg::SUM_W'(xsel_c) + bts_pkg::SUM_W'(rowsel_c);
  assign wxs_c    = is_cnt_q[0] ? is_wx1_q : is_wx0_q;
  assign wys_c    = is_cnt_q[1] ? is_wy1_q : is_wy0_q;
  assign wprod_c  = (2*bts_pkg::COORD_W)'(wxs_c) * (2*bts_pkg::COORD_W)'(wys_c);

  assign rd_in_c = 32'(sum_c) < DEPTH;
  assign wr_in_c = 32'(is_addr_q) < DEPTH;

  // Drive the store port: a write is a single access, a sample four reads
  assign ram_we_o    = is_v_q & (is_op_q == bts_pkg::OP_WRITE) & wr_in_c;
  assign ram_addr_o  = (is_op_q == bts_pkg::OP_WRITE) ? AW'(is_addr_q) : AW'(sum_c);
  assign ram_wdata_o = is_rgb_q;

  // Align read info with the registered store data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0;
    end else begin
      rd_q.valid    <= is_v_q & (is_op_q == bts_pkg::OP_SAMPLE);
      rd_q.in_range <= rd_in_c;
      rd_q.first    <= is_cnt_q == 2'd0;
      rd_q.last     <= is_cnt_q == 2'd3;
      rd_q.wt       <= wprod_c[bts_pkg::WT_W-1:0];
    end
  end

  assign rd_o = rd_q;

endmodule

// ----- rtl/bts_blend.sv -----
// Per-channel weighting, accumulation with rounding, and the output queue.
module bts_blend (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bts_pkg::rd_info_t           rd_i,
  input  logic [bts_pkg::RGB_W-1:0]   ram_rdata_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bts_pkg::RGB_W-1:0]   out_data_o
);

  // ---------------- weight each channel of the fetched texel ----------------
  logic [bts_pkg::PROD_W-1:0] prod_c [3];
  logic [bts_pkg::ACC_W-1:0]  m_prod_q [3];
  logic                       m_v_q, m_first_q, m_last_q;

  for (genvar c = 0; c < 3; c++) begin : g_mul
    logic [bts_pkg::CH_W-1:0] ch_c;
    // channel 0 is red in the top byte of the stored texel
    assign ch_c = ram_rdata_i[bts_pkg::RGB_W-1-bts_pkg::CH_W*c -: bts_pkg::CH_W];
    assign prod_c[c] = rd_i.in_range
                     ? bts_pkg::PROD_W'(ch_c) * bts_pkg::PROD_W'(rd_i.wt)
                     : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q     <= 1'b0;
      m_first_q <= 1'b0;
      m_last_q  <= 1'b0;
    end else begin
      m_v_q     <= rd_i.valid;
      m_first_q <= rd_i.first;
      m_last_q  <= rd_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      m_prod_q[c] <= prod_c[c][bts_pkg::ACC_W-1:0];
    end
  end

  // ---------------- accumulate, seeded with the rounding half ----------------
  logic [bts_pkg::ACC_W-1:0] acc_q [3];
  logic [bts_pkg::ACC_W-1:0] acc_d [3];
  logic [bts_pkg::RGB_W-1:0] res_c;
  logic                      push;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc_d[c] = (m_first_q ? bts_pkg::ROUND_HALF : acc_q[c]) + m_prod_q[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_v_q) begin
      for (int c = 0; c < 3; c++) begin
        acc_q[c] <= acc_d[c];
      end
    end
  end

  // Sum is below 256 * 2^32, so the top byte is the rounded channel
  assign res_c = {acc_d[2][bts_pkg::ACC_W-1 -: bts_pkg::CH_W],
                  acc_d[1][bts_pkg::ACC_W-1 -: bts_pkg::CH_W],
                  acc_d[0][bts_pkg::ACC_W-1 -: bts_pkg::CH_W]};
  assign push  = m_v_q & m_last_q;

  // ---------------- output queue, space reserved before reads start ----------------
  logic [bts_pkg::RGB_W-1:0]     q_mem_q [bts_pkg::OUT_DEPTH];
  logic [bts_pkg::OUT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [bts_pkg::OUT_CNT_W-1:0] cnt_q;
  logic                          pop;

  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = q_mem_q[rd_ptr_q];
  assign pop         = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + bts_pkg::OUT_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + bts_pkg::OUT_PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + bts_pkg::OUT_CNT_W'(1);
      end else if (!push && pop) begin
        cnt_q <= cnt_q - bts_pkg::OUT_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= res_c;
    end
  end

endmodule

// ----- rtl/bilinear_texture_sampler_top.sv -----
// Top level of the bilinear texture sampler: ports, size registers and instances.
//
// Usage:
//   s_axis carries one item per beat. tuser is the opcode: write stores the
//   texel in tdata at texel_addr and gives no result; sample filters the four
//   texels around (u, 1-v) and gives one RGB beat on m_axis.
//   The cfg channel writes tex_width (index 0) and tex_height (index 1); write
//   it only while no item is in flight. cfg_ready_o is always high.
// Store port:
//   All texels live in one single-port store, so a sample holds the port
//   for one read per corner and a write for a single access. Writes go one
//   per cycle while no sample holds the port or waits for queue space; items
//   of any mix are handled in order, each starting as the one before ends.
// Reset:
//   rst_ni clears the pipeline and sets both sizes to 256. The store is not
//   cleared; sample only texels that have been written.
// Stalls:
//   Results wait in a 2-entry output queue. When m_axis_tready stays low the
//   sequencer stops starting samples once the queue space is reserved, and
//   s_axis_tready drops as the input stage fills; nothing is lost.
module bilinear_texture_sampler_top #(
  parameter int MAX_WIDTH  = bts_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bts_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: texel_addr[15:0], texel_red[23:16], texel_green[31:24],
  //        texel_blue[39:32], coord_u[56:40], coord_v[73:57], zero[79:74]
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [bts_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: opcode[0]
  input  logic                              s_axis_tuser,
  // tdata: out_red[7:0], out_green[15:8], out_blue[23:16]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [bts_pkg::RGB_W-1:0]         m_axis_tdata,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bts_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bts_pkg::SIZE_W-1:0]        cfg_data_i
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  // ---------------- size registers ----------------
  logic [bts_pkg::SIZE_W-1:0] tex_width_q, tex_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_width_q  <= bts_pkg::SIZE_RESET;
      tex_height_q <= bts_pkg::SIZE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == bts_pkg::REG_TEX_WIDTH) begin
        tex_width_q <= cfg_data_i;
      end else if (cfg_index_i == bts_pkg::REG_TEX_HEIGHT) begin
        tex_height_q <= cfg_data_i;
      end
    end
  end

  // ---------------- unpack the input beat ----------------
  logic [bts_pkg::ADDR_W-1:0]  in_addr;
  logic [bts_pkg::RGB_W-1:0]   in_rgb;
  logic [bts_pkg::COORD_W-1:0] in_u, in_v;

  assign in_addr = s_axis_tdata[15:0];
  // store layout: red 23..16, green 15..8, blue 7..0
  assign in_rgb  = {s_axis_tdata[23:16], s_axis_tdata[31:24], s_axis_tdata[39:32]};
  assign in_u    = s_axis_tdata[56:40];
  assign in_v    = s_axis_tdata[73:57];

  // ---------------- sequencer and store ----------------
  logic                      ram_we;
  logic [AW-1:0]             ram_addr;
  logic [bts_pkg::RGB_W-1:0] ram_wdata, ram_rdata;
  bts_pkg::rd_info_t         rd_info;
  logic                      pop;

  assign pop = m_axis_tvalid & m_axis_tready;

  bts_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_op_i      (bts_pkg::op_e'(s_axis_tuser)),
    .in_addr_i    (in_addr),
    .in_rgb_i     (in_rgb),
    .in_u_i       (in_u),
    .in_v_i       (in_v),
    .tex_width_i  (tex_width_q),
    .tex_height_i (tex_height_q),
    .pop_i        (pop),
    .ram_we_o     (ram_we),
    .ram_addr_o   (ram_addr),
    .ram_wdata_o  (ram_wdata),
    .rd_o         (rd_info)
  );

  bts_ram #(
    .DATA_W (bts_pkg::RGB_W),
    .DEPTH  (DEPTH),
    .AW     (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // ---------------- blend and output ----------------
  bts_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_i        (rd_info),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
